// ===== hw/rtl/nwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nwa_pkg;

    // Default automaton size
    localparam int NUM_STATES_DEF  = 16;
    localparam int SYMBOL_BITS_DEF = 8;

    // Fixed beat field widths
    localparam int KIND_W   = 2;
    localparam int STATE_W  = 4;
    localparam int SYM_W    = 8;
    localparam int SET_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd1;

endpackage

`default_nettype wire

// ===== hw/rtl/nwa_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nwa_in_if import nwa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol;

    modport source (output valid, kind, from_state, to_state, symbol, input ready);
    modport sink   (input valid, kind, from_state, to_state, symbol, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nwa_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nwa_out_if import nwa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [SET_W-1:0] active_states;
    logic             dead;

    modport source (output valid, accepted, active_states, dead, input ready);
    modport sink   (input valid, accepted, active_states, dead, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nwa_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Transition memory: one entry per (state, symbol), one target bit per state.
module nwa_store import nwa_pkg::*; #(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int SW    = $clog2(NUM_STATES),
    localparam int AW    = SW + SYMBOL_BITS,
    localparam int DEPTH = NUM_STATES << SYMBOL_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    output logic      [NUM_STATES-1:0] o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [NUM_STATES-1:0] i_wr_data
);

    logic [NUM_STATES-1:0] r_mem [DEPTH];
    logic [NUM_STATES-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/nfa_word_acceptor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// NFA word acceptor: tracks the active state set of an automaton held in one
// transition memory of NUM_STATES << SYMBOL_BITS entries. After reset a
// clearing pass writes every entry to zero, one per cycle, and no beat is
// taken until it ends; configuration writes are taken throughout. An edge
// beat is a read-modify-write of one entry. A symbol beat reads the entry of
// every state in turn through the single memory read port. One beat is
// handled at a time; a finished result sits in the output register while the
// next beat is accepted, and the block stalls only if a second result is
// ready before the first has been taken.
module nfa_word_acceptor import nwa_pkg::*; #(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    nwa_in_if.sink                    i_in,
    nwa_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int AW    = SW + SYMBOL_BITS;
    localparam int DEPTH = NUM_STATES << SYMBOL_BITS;
    localparam int EXT_W = 7;   // holds any state number up to 127
    localparam int WIDE_W = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [AW-1:0]          r_clr;
    logic [SW-1:0]          r_from;
    logic [SW-1:0]          r_to;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SW-1:0]          r_idx;
    logic                   r_issue;
    logic                   r_rd_pend;
    logic [SW-1:0]          r_rd_st;
    logic [NUM_STATES-1:0]  r_next;
    logic [NUM_STATES-1:0]  r_active;
    logic [SET_W-1:0]       r_acc_mask;
    logic [STATE_W-1:0]     r_start;
    logic                   r_out_valid;
    logic                   r_out_accepted;
    logic [SET_W-1:0]       r_out_set;
    logic                   r_out_dead;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic [EXT_W-1:0]       w_from_ext;
    logic [EXT_W-1:0]       w_to_ext;
    logic [EXT_W-1:0]       w_start_ext;
    logic                   w_edge_ok;
    logic [NUM_STATES-1:0]  w_start_bit;
    logic [NUM_STATES-1:0]  w_to_bit;
    logic [NUM_STATES-1:0]  w_acc;
    logic [WIDE_W-1:0]      w_act_ext;
    logic [SET_W-1:0]       w_act16;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic [NUM_STATES-1:0]  w_rd_data;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [NUM_STATES-1:0]  w_wr_data;

    // Handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_accepted;
    assign o_out.active_states = r_out_set;
    assign o_out.dead          = r_out_dead;

    // State number range checks and one-hot forms
    assign w_from_ext  = {3'b000, i_in.from_state};
    assign w_to_ext    = {3'b000, i_in.to_state};
    assign w_start_ext = {3'b000, r_start};
    assign w_edge_ok   = (w_from_ext < EXT_W'(NUM_STATES)) &&
                         (w_to_ext < EXT_W'(NUM_STATES));
    assign w_start_bit = (w_start_ext < EXT_W'(NUM_STATES)) ?
                         (NUM_STATES'(1) << w_start_ext[SW-1:0]) : '0;
    assign w_to_bit    = NUM_STATES'(1) << r_to;

    // Running union: fold in the entry just read if its state is active
    assign w_acc = r_next | (r_active[r_rd_st] ? w_rd_data : '0);

    // Report view of the active set
    assign w_act_ext = WIDE_W'(r_active);
    assign w_act16   = w_act_ext[SET_W-1:0];

    // Memory ports
    assign w_rd_en   = (r_state == ST_EDGE_RD) || ((r_state == ST_SCAN) && r_issue);
    assign w_rd_addr = (r_state == ST_SCAN) ? {r_idx, r_sym} : {r_from, r_sym};
    assign w_wr_en   = (r_state == ST_CLEAR) || (r_state == ST_EDGE_WR);
    assign w_wr_addr = (r_state == ST_CLEAR) ? r_clr : {r_from, r_sym};
    assign w_wr_data = (r_state == ST_CLEAR) ? '0 : (w_rd_data | w_to_bit);

    nwa_store #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_mask <= '0;
            r_start    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEPT_MASK: r_acc_mask <= i_cfg_data;
                CFG_START_STATE: r_start    <= i_cfg_data[STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_issue     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= NUM_STATES'(1);
        end else begin
            // result taken; ST_DONE sets or holds the valid itself
            if (o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_from <= w_from_ext[SW-1:0];
                        r_to   <= w_to_ext[SW-1:0];
                        r_sym  <= i_in.symbol[SYMBOL_BITS-1:0];
                        unique case (i_in.kind)
                            KIND_EDGE: begin
                                if (w_edge_ok) begin
                                    r_state <= ST_EDGE_RD;
                                end
                            end
                            KIND_BEGIN: begin
                                r_active <= w_start_bit;
                                r_state  <= ST_DONE;
                            end
                            KIND_SYMBOL: begin
                                r_idx     <= '0;
                                r_issue   <= 1'b1;
                                r_rd_pend <= 1'b0;
                                r_next    <= '0;
                                r_state   <= ST_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EDGE_RD: begin
                    r_state <= ST_EDGE_WR;
                end
                ST_EDGE_WR: begin
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    // issue one read per state
                    if (r_issue) begin
                        r_rd_pend <= 1'b1;
                        r_rd_st   <= r_idx;
                        r_idx     <= r_idx + SW'(1);
                        if (r_idx == SW'(NUM_STATES - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    // gather the entry read last cycle
                    if (r_rd_pend) begin
                        r_next <= w_acc;
                        if (r_rd_st == SW'(NUM_STATES - 1)) begin
                            r_rd_pend <= 1'b0;
                            r_active  <= w_acc;
                            r_state   <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_accepted <= (w_act16 & r_acc_mask) != '0;
                        r_out_set      <= w_act16;
                        r_out_dead     <= (r_active == '0);
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // no beat taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready)
        else $error("input ready during clearing pass");

    // a symbol beat starts a scan at the first state
    a_symbol_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.kind == KIND_SYMBOL)) |=>
            ((r_state == ST_SCAN) && (r_idx == '0) && r_issue))
        else $error("symbol beat did not start a scan");

    // the memory is never written during a scan
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_wr_en)
        else $error("transition memory written during scan");

    // a result is never overwritten before it is taken
    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> (r_state == ST_DONE))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
